// ----- design/pinc_pkg.sv -----
// Package for the painted interval cover counter.
// Shared constants for request/response packing and default map size.
// No dependencies.
package pinc_pkg;

   localparam int DEF_NUM_CELLS = 65536;

   localparam int START_W    = 16;
   localparam int END_W      = 17;
   localparam int OUT_W      = 17;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - OUT_W;

endpackage

// ----- design/painted_interval_new_cover_counter_top.sv -----
// Top level of the painted interval cover counter.
// Depends on pinc_pkg and pinc_ram.
//
// Each request names a half-open interval [start_pos, end_pos) of a map of NUM_CELLS
// cells and returns how many of its cells were still unpainted, then paints them all.
// The map is a segment tree of painted counts held in one RAM of 2*NUM_CELLS entries;
// a full node stands for its whole subtree. A small sequencer walks the tree depth
// first with a per-level stack. Each visited node passes through a RAM read state, then
// an evaluate state, and a return state on the way back up; at most four nodes per
// level are visited (two just below the root), and an empty interval skips the walk.
// After reset a clearing pass over all 2*NUM_CELLS entries runs before the first
// request is taken. One request is in flight at a time; the result register lets the
// next request enter while the previous result waits.
module painted_interval_new_cover_counter_top #(
   parameter int NUM_CELLS = pinc_pkg::DEF_NUM_CELLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] start_pos, [32:16] end_pos
   input  logic [pinc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [16:0] newly_painted
   output logic [pinc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import pinc_pkg::*;

   localparam int LOG   = $clog2(NUM_CELLS);
   localparam int CNT_W = LOG + 1;
   localparam int NODES = 2 * NUM_CELLS;
   localparam int DW    = $clog2(LOG + 1);
   localparam int SW    = (LOG > 1) ? $clog2(LOG) : 1;
   localparam int CW    = (CNT_W > END_W) ? CNT_W : END_W;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_RETURN = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam logic [CW-1:0] MAP_END = CW'(NUM_CELLS);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] node_ff, node_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    span_ff, span_in;
   logic [CW-1:0]    lpos_ff, lpos_in;
   logic [CW-1:0]    rpos_ff, rpos_in;
   logic [CNT_W-1:0] ret_ff, ret_in;
   logic [CNT_W-1:0] old_stk_ff [LOG];
   logic [CNT_W-1:0] gain_stk_ff [LOG];
   logic             push_en, gain_en;
   logic [SW-1:0]    push_idx, pop_idx;
   logic [CNT_W-1:0] gain_wr;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;

   logic             ram_we;
   logic [CNT_W-1:0] ram_waddr;
   logic [CNT_W-1:0] ram_wdata;
   logic [CNT_W-1:0] ram_rdata;

   logic [CW-1:0]    hi;
   logic [CW-1:0]    cnt_ext;
   logic [CW-1:0]    end_ext;
   logic [CW-1:0]    ret_ext;
   logic [DW-1:0]    parent_depth;
   logic [CNT_W-1:0] total;
   logic             no_ovl, full_node, covered;

   pinc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (node_ff),
      .rd_data (ram_rdata)
   );

   assign hi           = lo_ff + span_ff;
   assign cnt_ext      = CW'(ram_rdata);
   assign end_ext      = CW'(req_tdata[START_W +: END_W]);
   assign ret_ext      = CW'(ret_ff);
   assign parent_depth = depth_ff - DW'(1);
   assign push_idx     = depth_ff[SW-1:0];
   assign pop_idx      = parent_depth[SW-1:0];
   assign total        = gain_stk_ff[pop_idx] + ret_ff;
   assign no_ovl       = (rpos_ff <= lo_ff) || (hi <= lpos_ff);
   assign full_node    = (cnt_ext == span_ff);
   assign covered      = (lpos_ff <= lo_ff) && (hi <= rpos_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      lpos_in      = lpos_ff;
      rpos_in      = rpos_ff;
      ret_in       = ret_ff;
      push_en      = 1'b0;
      gain_en      = 1'b0;
      gain_wr      = ret_ff;
      ram_we       = 1'b0;
      ram_waddr    = node_ff;
      ram_wdata    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + CNT_W'(1);
            if (clr_ff == {CNT_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               lpos_in  = CW'(req_tdata[START_W-1:0]);
               rpos_in  = (end_ext > MAP_END) ? MAP_END : end_ext;
               node_in  = CNT_W'(1);
               depth_in = '0;
               lo_in    = '0;
               span_in  = MAP_END;
               ret_in   = '0;
               if (CW'(req_tdata[START_W-1:0]) < ((end_ext > MAP_END) ? MAP_END : end_ext))
               begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (no_ovl || full_node) begin
               ret_in   = '0;
               state_in = ST_RETURN;
            end else if (covered) begin
               ret_in    = CNT_W'(span_ff - cnt_ext);
               ram_we    = 1'b1;
               ram_waddr = node_ff;
               ram_wdata = CNT_W'(span_ff);
               state_in  = ST_RETURN;
            end else begin
               push_en  = 1'b1;
               node_in  = {node_ff[CNT_W-2:0], 1'b0};
               depth_in = depth_ff + DW'(1);
               span_in  = span_ff >> 1;
               state_in = ST_READ;
            end
         end
         ST_RETURN: begin
            if (depth_ff == '0) begin
               state_in = ST_DONE;
            end else if (!node_ff[0]) begin
               gain_en  = 1'b1;
               gain_wr  = ret_ff;
               node_in  = node_ff | CNT_W'(1);
               lo_in    = lo_ff + span_ff;
               state_in = ST_READ;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = node_ff >> 1;
               ram_wdata = old_stk_ff[pop_idx] + total;
               ret_in    = total;
               node_in   = node_ff >> 1;
               depth_in  = parent_depth;
               lo_in     = lo_ff - span_ff;
               span_in   = span_ff << 1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ret_ext[OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      depth_ff    <= depth_in;
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      lpos_ff     <= lpos_in;
      rpos_ff     <= rpos_in;
      ret_ff      <= ret_in;
      rsp_data_ff <= rsp_data_in;
      if (push_en) begin
         old_stk_ff[push_idx]  <= ram_rdata;
         gain_stk_ff[push_idx] <= '0;
      end
      if (gain_en) begin
         gain_stk_ff[pop_idx] <= gain_wr;
      end
   end

endmodule

// ----- design/pinc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the segment tree node counts. No dependencies.
module pinc_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pinc_checker.sv -----
// Port-level checker for the painted interval cover counter, bound to the top.
// Depends on painted_interval_new_cover_counter_top.
module pinc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("not clearing after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:17] == 7'd0 && rsp_tdata[16:0] <= 17'h10000)
      else $error("count out of range");

endmodule

bind painted_interval_new_cover_counter_top pinc_checker u_pinc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/tb_top.sv -----
// Testbench for painted_interval_new_cover_counter_top: directed and random interval requests.
// A segment-tree predictor of painted counts checks every newly_painted response in order.
// Depends on pinc_pkg and the design files.
module tb_top;

   localparam int MAP_CELLS = pinc_pkg::DEF_NUM_CELLS;
   localparam int IDLE_PCT  = 29;

   typedef struct packed {
      logic [pinc_pkg::END_W-1:0]   end_cell;
      logic [pinc_pkg::START_W-1:0] first_cell;
   } span_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pinc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pinc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   span_type                     plan_q[$];
   logic [pinc_pkg::OUT_W-1:0]   gain_q[$];
   int unsigned                  painted_cnt[1:2*MAP_CELLS-1];
   int                           req_count = 0;
   int                           req_issued = 0;
   int                           fault_count = 0;

   painted_interval_new_cover_counter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // A node whose count equals its span stays full for good, so it is never entered again.
   function automatic int unsigned paint_cells(int unsigned node, int unsigned lo,
                                               int unsigned span, int unsigned first,
                                               int unsigned last);
      int unsigned half, got;
      if (last <= lo || lo + span <= first) return 0;
      if (painted_cnt[node] == span) return 0;
      if (first <= lo && lo + span <= last) begin
         got = span - painted_cnt[node];
         painted_cnt[node] = span;
         return got;
      end
      half = span / 2;
      got = paint_cells(2 * node, lo, half, first, last);
      got = got + paint_cells(2 * node + 1, lo + half, half, first, last);
      painted_cnt[node] = painted_cnt[2 * node] + painted_cnt[2 * node + 1];
      return got;
   endfunction

   function automatic logic [pinc_pkg::OUT_W-1:0] predict_new_cells(
         logic [pinc_pkg::START_W-1:0] first, logic [pinc_pkg::END_W-1:0] last);
      int unsigned stop, got;
      stop = (last > MAP_CELLS) ? MAP_CELLS : 32'(last);
      if (first >= stop) return '0;
      got = paint_cells(1, 0, MAP_CELLS, 32'(first), stop);
      return got[pinc_pkg::OUT_W-1:0];
   endfunction

   task automatic add_span(int unsigned first, int unsigned last);
      span_type s;
      s.first_cell = first[pinc_pkg::START_W-1:0];
      s.end_cell   = last[pinc_pkg::END_W-1:0];
      plan_q.push_back(s);
   endtask

   function automatic bit calm_window();
      return req_count >= 600 && req_count < 900;
   endfunction

   // driver
   always @(negedge clock) begin : drive
      span_type nxt;
      bit       draining;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         // full drain before sending past these points
         draining = (req_count == 16 || req_count == 1000) && gain_q.size() != 0;
         if (req_count == req_issued) begin
            if (plan_q.size() != 0 && !draining &&
                (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = plan_q.pop_front();
               req_tdata  <= {{(pinc_pkg::REQ_DATA_W - pinc_pkg::START_W - pinc_pkg::END_W){1'b0}},
                              nxt.end_cell, nxt.first_cell};
               req_tvalid <= 1'b1;
               req_issued = req_issued + 1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= calm_window() || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      logic [pinc_pkg::OUT_W-1:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (gain_q.size() == 0) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10)
                  $display("unexpected response: newly_painted %0d",
                           rsp_tdata[pinc_pkg::OUT_W-1:0]);
            end else begin
               want = gain_q.pop_front();
               if (rsp_tdata[pinc_pkg::OUT_W-1:0] !== want) begin
                  fault_count = fault_count + 1;
                  if (fault_count <= 10)
                     $display("newly_painted mismatch: expected %0d, got %0d",
                              want, rsp_tdata[pinc_pkg::OUT_W-1:0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            gain_q.push_back(predict_new_cells(req_tdata[pinc_pkg::START_W-1:0],
                  req_tdata[pinc_pkg::START_W +: pinc_pkg::END_W]));
            req_count <= req_count + 1;
         end
      end
   end

   initial begin
      int unsigned s, e, pick;
      int          k;
      // directed
      add_span(0, 0);
      add_span(5, 3);
      add_span(65535, 0);
      add_span(0, 1);
      add_span(65535, 65536);
      add_span(65535, 131071);
      add_span(0, 1);
      add_span(1, 4);
      add_span(0, 8);
      add_span(100, 100);
      add_span(40000, 42048);
      add_span(41000, 41100);
      add_span(39990, 42100);
      add_span(65000, 65636);
      add_span(32767, 32769);
      add_span(16383, 16385);
      // random, mostly short intervals so the map fills slowly
      for (k = 0; k < 1830; k++) begin
         s = $urandom_range(0, 65535);
         pick = $urandom_range(0, 99);
         if (pick < 3)       e = $urandom_range(0, s);
         else if (pick < 78) e = s + $urandom_range(1, 16);
         else if (pick < 98) e = s + $urandom_range(17, 256);
         else                e = s + $urandom_range(257, 2048);
         add_span(s, e);
      end
      // whole-map extremes last
      add_span(1, 65535);
      add_span(0, 65536);
      add_span(0, 131071);

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (plan_q.size() != 0 || req_count != req_issued || gain_q.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (fault_count == 0 && gain_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #6000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
design/pinc_pkg.sv
design/pinc_ram.sv
design/painted_interval_new_cover_counter_top.sv
design/pinc_checker.sv
sim/tb_top.sv
